// ----- sv/frs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_pkg
// shared types and constants of the fenced ring suballocator
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam int unsigned OFF_W   = 31;  // byte offsets and sizes
  localparam int unsigned GEN_W   = 16;
  localparam int unsigned CNT_W   = 7;   // live_count field
  localparam int unsigned CLG_W   = 5;
  localparam int unsigned ALG_W   = 5;
  localparam int unsigned CLG_MIN = 12;
  localparam int unsigned CLG_MAX = 30;
  localparam int unsigned ALG_MAX = 16;
  localparam int unsigned CLG_RST = 23;
  localparam int unsigned IN_W    = 104;
  localparam int unsigned OUT_W   = 88;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RECLAIM = 1'b1;

  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_DEDIC   = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_RECLAIM = 2'd3;

  localparam logic REG_CAP_LOG2 = 1'b0;
  localparam logic REG_FORCE    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RECL,
    S_PREP,
    S_TRY_A,
    S_TRY_B,
    S_COMMIT,
    S_DONE
  } seq_state_e;

  // control broadcast along the row of cells
  typedef struct packed {
    logic pop;  // every cell takes its upper neighbor
    logic wr;   // the addressed cell loads the new entry
  } cell_ctl_t;

endpackage

// ----- sv/fenced_ring_suballocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenced_ring_suballocator
// ring suballocator over one fixed-size slab with in-order fence reclaim
// ----------------------------------------------------------------------------
// Live allocations sit oldest-first in a row of MAX_LIVE cells. Reclaim pops
// one entry per cycle by shifting the whole row toward the head. A zero-size
// request goes straight to the result; any other item first retires entries,
// then a reclaim-only item finishes, a dedicated request is decided in the
// prepare step, a full live list makes the slab rotate, and a placed request
// gets one probe at the aligned cursor and, if that fails, a second one at
// offset 0, in which every cell checks the candidate slice for overlap at
// once. The second probe needs a live entry left after reclaim. One item is
// worked on at a time, but a new word is taken while the previous result waits
// in the output register.
module fenced_ring_suballocator
  import frs_pkg::*;
#(
  parameter int unsigned MAX_LIVE = 64,
  parameter int unsigned SEQ_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CLG_W-1:0]   cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // cmd
  input  logic               s_axis_tuser,
  // req_size, align_log2, seq_id, completed_seq, zero pad
  input  logic [IN_W-1:0]    s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // status
  output logic [1:0]         m_axis_tuser,
  // place_offset, granted_size, slab_generation, rotated, live_count, zero pad
  output logic [OUT_W-1:0]   m_axis_tdata
);

  localparam int unsigned IW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
  localparam int unsigned FW = $clog2(MAX_LIVE + 1);

  // configuration
  logic [CLG_W-1:0] clg_q;
  logic             force_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clg_q   <= CLG_W'(CLG_RST);
      force_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_CAP_LOG2) clg_q <= cfg_wdata_i;
      else                           force_q <= cfg_wdata_i[0];
    end
  end

  logic [CLG_W-1:0] clg_sat;
  logic [OFF_W:0]   cap;  // up to 2^30
  assign clg_sat = (clg_q < CLG_W'(CLG_MIN)) ? CLG_W'(CLG_MIN) :
                   (clg_q > CLG_W'(CLG_MAX)) ? CLG_W'(CLG_MAX) : clg_q;
  assign cap = (OFF_W+1)'(1) << clg_sat;

  // input word fields
  logic              in_cmd;
  logic [OFF_W-1:0]  in_size;
  logic [ALG_W-1:0]  in_alg, in_alg_sat;
  logic [31:0]       in_seq, in_done;
  assign in_cmd     = s_axis_tuser;
  assign in_size    = s_axis_tdata[30:0];
  assign in_alg     = s_axis_tdata[35:31];
  assign in_seq     = s_axis_tdata[67:36];
  assign in_done    = s_axis_tdata[99:68];
  assign in_alg_sat = (in_alg > ALG_W'(ALG_MAX)) ? ALG_W'(ALG_MAX) : in_alg;

  // item registers
  seq_state_e        state_q, state_d;
  logic              cmd_q;
  logic [OFF_W-1:0]  size_q;
  logic [ALG_W-1:0]  alg_q;
  logic [SEQ_BITS-1:0] seq_q, done_q;
  logic [OFF_W:0]    asz_q;     // aligned size, may reach 2^31
  logic [OFF_W:0]    probe_q;   // candidate offset
  logic [1:0]        status_q;
  logic              rot_q;

  // slab state
  logic [FW-1:0]     fill_q;
  logic [OFF_W-1:0]  cursor_q;
  logic [OFF_W-1:0]  last_off_q;  // offset of the newest live entry
  logic [GEN_W-1:0]  gen_q;

  // output register
  logic              out_vld_q;
  logic [OUT_W-1:0]  out_q;
  logic [1:0]        out_user_q;

  // aligned size of the incoming request
  logic [OFF_W:0] amask_in, asz_in;
  assign amask_in = ((OFF_W+1)'(1) << in_alg_sat) - (OFF_W+1)'(1);
  assign asz_in   = ({1'b0, in_size} + amask_in) & ~amask_in;

  // aligned cursor
  logic [OFF_W:0] amask_q, cur_al;
  assign amask_q = ((OFF_W+1)'(1) << alg_q) - (OFF_W+1)'(1);
  assign cur_al  = ({1'b0, cursor_q} + amask_q) & ~amask_q;

  // row of cells
  cell_ctl_t           ctl;
  logic [IW-1:0]       wr_idx;
  logic [OFF_W+1:0]    probe_end;
  logic [OFF_W-1:0]    c_off  [MAX_LIVE];
  logic [OFF_W-1:0]    c_span [MAX_LIVE];
  logic [SEQ_BITS-1:0] c_seq  [MAX_LIVE];
  logic [MAX_LIVE-1:0] c_hit;

  assign probe_end = {1'b0, probe_q} + {1'b0, asz_q};

  for (genvar g = 0; g < MAX_LIVE; g++) begin : g_cell
    logic [OFF_W-1:0]    nb_off, nb_span;
    logic [SEQ_BITS-1:0] nb_seq;
    if (g == MAX_LIVE - 1) begin : g_end
      assign nb_off  = '0;
      assign nb_span = '0;
      assign nb_seq  = '0;
    end else begin : g_mid
      assign nb_off  = c_off[g+1];
      assign nb_span = c_span[g+1];
      assign nb_seq  = c_seq[g+1];
    end
    frs_cell #(.SEQ_BITS(SEQ_BITS), .IW(IW), .IDX(g)) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .wr_idx_i    (wr_idx),
      .wr_off_i    (probe_q[OFF_W-1:0]),
      .wr_span_i   (asz_q[OFF_W-1:0]),
      .wr_seq_i    (seq_q),
      .nb_off_i    (nb_off),
      .nb_span_i   (nb_span),
      .nb_seq_i    (nb_seq),
      .valid_i     (fill_q > FW'(g)),
      .probe_i     (probe_q),
      .probe_end_i (probe_end),
      .off_o       (c_off[g]),
      .span_o      (c_span[g]),
      .seq_o       (c_seq[g]),
      .hit_o       (c_hit[g])
    );
  end

  logic any_hit, can_pop, fast_ok, cap_ok_a, out_free;
  assign any_hit  = |c_hit;
  assign can_pop  = (fill_q != '0) && (c_seq[0] <= done_q);
  assign fast_ok  = (fill_q == '0) || (c_off[0] <= last_off_q);
  assign cap_ok_a = probe_end <= {1'b0, cap};
  assign out_free = !out_vld_q || m_axis_tready;
  assign wr_idx   = rot_q ? '0 : fill_q[IW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_cmd == CMD_ALLOC && in_size == '0) state_d = S_DONE;
          else                                      state_d = S_RECL;
        end
      end
      S_RECL: begin
        if (!can_pop) state_d = (cmd_q == CMD_RECLAIM) ? S_DONE : S_PREP;
      end
      S_PREP: begin
        if (force_q || asz_q > cap)           state_d = S_DONE;
        else if (fill_q == FW'(MAX_LIVE))     state_d = S_COMMIT;
        else                                  state_d = S_TRY_A;
      end
      S_TRY_A: state_d = (cap_ok_a && (fast_ok || !any_hit)) ? S_COMMIT : S_TRY_B;
      S_TRY_B: state_d = S_COMMIT;
      S_COMMIT: state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    ctl.pop       = (state_q == S_RECL) && can_pop;
    ctl.wr        = (state_q == S_COMMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q    <= in_cmd;
        size_q   <= in_size;
        alg_q    <= in_alg_sat;
        seq_q    <= SEQ_BITS'(in_seq);
        done_q   <= SEQ_BITS'(in_done);
        asz_q    <= asz_in;
        probe_q  <= '0;
        rot_q    <= 1'b0;
        status_q <= (in_cmd == CMD_RECLAIM) ? ST_RECLAIM : ST_EMPTY;
      end
      S_PREP: begin
        if (force_q || asz_q > cap) begin
          status_q <= ST_DEDIC;
        end else begin
          status_q <= ST_PLACED;
          probe_q  <= cur_al;
          rot_q    <= (fill_q == FW'(MAX_LIVE));
          if (fill_q == FW'(MAX_LIVE)) probe_q <= '0;
        end
      end
      S_TRY_A: if (!(cap_ok_a && (fast_ok || !any_hit))) probe_q <= '0;
      S_TRY_B: rot_q <= !cap_ok_a || any_hit;
      default: ;
    endcase
  end

  // slab state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      cursor_q   <= '0;
      last_off_q <= '0;
      gen_q      <= '0;
    end else begin
      if (ctl.pop) fill_q <= fill_q - FW'(1);
      if (state_q == S_RECL && !can_pop && fill_q == '0) cursor_q <= '0;
      if (state_q == S_COMMIT) begin
        if (rot_q) begin
          gen_q      <= gen_q + GEN_W'(1);
          fill_q     <= FW'(1);
          cursor_q   <= asz_q[OFF_W-1:0];
          last_off_q <= '0;
        end else begin
          fill_q     <= fill_q + FW'(1);
          cursor_q   <= probe_q[OFF_W-1:0] + asz_q[OFF_W-1:0];
          last_off_q <= probe_q[OFF_W-1:0];
        end
      end
    end
  end

  // output register
  logic [OFF_W-1:0] res_off, res_granted;
  assign res_off     = (status_q == ST_PLACED && !rot_q) ? probe_q[OFF_W-1:0] : '0;
  assign res_granted = (status_q == ST_PLACED || status_q == ST_DEDIC) ? size_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_q      <= {2'b00, CNT_W'(fill_q), rot_q && (status_q == ST_PLACED), gen_q,
                     res_granted, res_off};
      out_user_q <= status_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_LIVE)) else $error("live fill above capacity");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.pop |-> fill_q != '0) else $error("pop on empty live list");

  a_pop_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.pop && ctl.wr)) else $error("pop and write in one cycle");

  a_commit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT |=> state_q == S_DONE && fill_q != '0)
    else $error("commit left list empty");

endmodule

// ----- sv/frs_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_cell
// one live allocation slot: shifts toward the head, checks a probe for overlap
// ----------------------------------------------------------------------------
module frs_cell
  import frs_pkg::*;
#(
  parameter int unsigned SEQ_BITS = 32,
  parameter int unsigned IW       = 6,
  parameter int unsigned IDX      = 0
) (
  input  logic                clk_i,
  input  cell_ctl_t           ctl_i,
  input  logic [IW-1:0]       wr_idx_i,
  input  logic [OFF_W-1:0]    wr_off_i,
  input  logic [OFF_W-1:0]    wr_span_i,
  input  logic [SEQ_BITS-1:0] wr_seq_i,
  input  logic [OFF_W-1:0]    nb_off_i,
  input  logic [OFF_W-1:0]    nb_span_i,
  input  logic [SEQ_BITS-1:0] nb_seq_i,
  input  logic                valid_i,
  input  logic [OFF_W:0]      probe_i,
  input  logic [OFF_W+1:0]    probe_end_i,
  output logic [OFF_W-1:0]    off_o,
  output logic [OFF_W-1:0]    span_o,
  output logic [SEQ_BITS-1:0] seq_o,
  output logic                hit_o
);

  logic [OFF_W-1:0]    off_q, span_q;
  logic [SEQ_BITS-1:0] seq_q;
  logic [OFF_W+1:0]    end_w;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pop) begin
      off_q  <= nb_off_i;
      span_q <= nb_span_i;
      seq_q  <= nb_seq_i;
    end else if (ctl_i.wr && (wr_idx_i == IW'(IDX))) begin
      off_q  <= wr_off_i;
      span_q <= wr_span_i;
      seq_q  <= wr_seq_i;
    end
  end

  assign end_w  = {2'b00, off_q} + {2'b00, span_q};
  assign hit_o  = valid_i && !((probe_end_i <= {2'b00, off_q}) || ({1'b0, probe_i} >= end_w));
  assign off_o  = off_q;
  assign span_o = span_q;
  assign seq_o  = seq_q;

endmodule

// ----- dv/tb_fenced_ring_suballocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fenced_ring_suballocator
// self-checking bench for the fenced ring suballocator
// ----------------------------------------------------------------------------
// A directed table of requests runs first, then random allocate and reclaim
// traffic under several idling phases and capacity / force settings. Every
// result word is compared field by field against an in-bench ring model that
// tracks live slices, the ring cursor and the slab generation.
module tb_fenced_ring_suballocator;
  import frs_pkg::*;

  localparam int unsigned LIVE_MAX  = 64;
  localparam longint      CYC_LIMIT = 2_000_000;
  localparam int unsigned EXP_DEPTH = 1024;
  localparam int unsigned ROW_MAX   = 16;

  typedef struct packed {
    logic [31:0]      done_seq;
    logic [31:0]      tag_seq;
    logic [ALG_W-1:0] alg;
    logic [OFF_W-1:0] nbytes;
    logic             cmd;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] live;
    logic             rot;
    logic [GEN_W-1:0] gen;
    logic [OFF_W-1:0] granted;
    logic [OFF_W-1:0] offset;
    logic [1:0]       status;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = REG_CAP_LOG2;
  logic [CLG_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic s_axis_tuser = 1'b0;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [1:0] m_axis_tuser;
  logic [OUT_W-1:0] m_axis_tdata;

  fenced_ring_suballocator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ring model state
  longint unsigned slice_off [LIVE_MAX];
  longint unsigned slice_len [LIVE_MAX];
  longint unsigned slice_seq [LIVE_MAX];
  int unsigned     ring_head, ring_fill;
  longint unsigned cursor;
  int unsigned     slab_gen;
  int unsigned     cap_log2_reg = CLG_RST;
  bit              force_reg;

  // expected result words, written at input accept and taken at output accept
  grant_t      exp_mem [EXP_DEPTH];
  int unsigned exp_wr, exp_rd;
  int          fail_cnt;
  longint      cycle_cnt;

  // idling controls
  int unsigned send_idle_pct, recv_stall_pct;
  bit          hold_recv;

  function automatic longint unsigned round_up(longint unsigned v, int unsigned lg);
    longint unsigned a;
    a = 64'd1 << lg;
    return (v + a - 1) & ~(a - 1);
  endfunction

  function automatic bit slice_free(longint unsigned off, longint unsigned sz,
                                    longint unsigned cap);
    int unsigned s;
    if (off + sz > cap) return 0;
    for (int i = 0; i < ring_fill; i++) begin
      s = (ring_head + i) % LIVE_MAX;
      if (!(off + sz <= slice_off[s] || off >= slice_off[s] + slice_len[s])) return 0;
    end
    return 1;
  endfunction

  function automatic bit ring_unwrapped(longint unsigned off, longint unsigned sz,
                                        longint unsigned cap);
    if (off + sz > cap) return 0;
    if (ring_fill == 0) return 1;
    return slice_off[ring_head] <= slice_off[(ring_head + ring_fill - 1) % LIVE_MAX];
  endfunction

  function automatic void retire_done(longint unsigned done);
    while (ring_fill > 0 && slice_seq[ring_head] <= done) begin
      ring_head = (ring_head + 1) % LIVE_MAX;
      ring_fill--;
    end
    if (ring_fill == 0) cursor = 0;
  endfunction

  // work out the grant for one request and advance the ring model
  function automatic grant_t place_request(req_t r);
    grant_t g;
    int unsigned clg, alg, s;
    longint unsigned cap, asz, off;
    bit rot;
    clg = cap_log2_reg < CLG_MIN ? CLG_MIN : (cap_log2_reg > CLG_MAX ? CLG_MAX : cap_log2_reg);
    alg = r.alg > ALG_MAX ? ALG_MAX : r.alg;
    cap = 64'd1 << clg;
    off = 0;
    rot = 0;
    g = '0;
    if (r.cmd == CMD_RECLAIM) begin
      retire_done(r.done_seq);
      g.status = ST_RECLAIM;
    end else if (r.nbytes == 0) begin
      g.status = ST_EMPTY;
    end else begin
      retire_done(r.done_seq);
      asz = round_up(r.nbytes, alg);
      g.granted = r.nbytes;
      if (force_reg || asz > cap) begin
        g.status = ST_DEDIC;
      end else begin
        g.status = ST_PLACED;
        if (ring_fill >= LIVE_MAX) begin
          rot = 1;
        end else begin
          off = round_up(cursor, alg);
          if (!ring_unwrapped(off, asz, cap) && !slice_free(off, asz, cap)) begin
            off = 0;
            if (!slice_free(0, asz, cap)) rot = 1;
          end
        end
        if (rot) begin
          slab_gen = (slab_gen + 1) & 16'hFFFF;
          ring_head = 0;
          ring_fill = 0;
          off = 0;
        end
        s = (ring_head + ring_fill) % LIVE_MAX;
        slice_off[s] = off;
        slice_len[s] = asz;
        slice_seq[s] = r.tag_seq;
        ring_fill++;
        cursor = (off + asz) & 64'h7FFF_FFFF;
      end
    end
    g.offset = off[OFF_W-1:0];
    g.gen    = slab_gen[GEN_W-1:0];
    g.rot    = rot;
    g.live   = ring_fill[CNT_W-1:0];
    return g;
  endfunction

  // receiver side: stall at random, compare with the oldest expectation
  always @(posedge clk_i) begin
    grant_t act, exp_g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = grant_t'({m_axis_tdata[OUT_W-3:0], m_axis_tuser});
      if (exp_wr == exp_rd) begin
        $error("unexpected result word %h %h", m_axis_tuser, m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_g = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (act.status !== exp_g.status) begin
          $error("status exp %0d got %0d", exp_g.status, act.status); fail_cnt++;
        end
        if (act.offset !== exp_g.offset) begin
          $error("place_offset exp %0h got %0h", exp_g.offset, act.offset); fail_cnt++;
        end
        if (act.granted !== exp_g.granted) begin
          $error("granted_size exp %0h got %0h", exp_g.granted, act.granted); fail_cnt++;
        end
        if (act.gen !== exp_g.gen) begin
          $error("slab_generation exp %0d got %0d", exp_g.gen, act.gen); fail_cnt++;
        end
        if (act.rot !== exp_g.rot) begin
          $error("rotated exp %0d got %0d", exp_g.rot, act.rot); fail_cnt++;
        end
        if (act.live !== exp_g.live) begin
          $error("live_count exp %0d got %0d", exp_g.live, act.live); fail_cnt++;
        end
      end
    end
    m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one request word through the handshake, with optional sender idling;
  // valid stays up after the accept so that words can follow back to back
  task automatic send_req(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tuser  <= r.cmd;
    s_axis_tdata  <= IN_W'({r.done_seq, r.tag_seq, r.alg, r.nbytes});
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_mem[exp_wr % EXP_DEPTH] = place_request(r);
    exp_wr++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (LIVE_MAX + 10) @(posedge clk_i);
  endtask

  // write enable is left high; the caller drops it after the last write
  task automatic write_reg(logic idx, int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CLG_W'(val);
    @(posedge clk_i);
    if (idx == REG_CAP_LOG2) cap_log2_reg = val;
    else force_reg = val[0];
  endtask

  // random request: mostly small allocations with rising tags and lagging fence
  int unsigned tag_ctr, fence_ctr;
  function automatic req_t rand_req();
    req_t r;
    int unsigned k;
    r.cmd    = ($urandom_range(9) == 0) ? CMD_RECLAIM : CMD_ALLOC;
    k        = $urandom_range(99);
    if (k < 4)       r.nbytes = '0;
    else if (k < 8)  r.nbytes = OFF_W'($urandom());
    else if (k < 30) r.nbytes = OFF_W'($urandom_range(1 << 14, 1));
    else             r.nbytes = OFF_W'($urandom_range(1024, 1));
    r.alg    = ($urandom_range(19) == 0) ? ALG_W'($urandom_range(31)) :
                                           ALG_W'($urandom_range(8));
    tag_ctr += $urandom_range(3);
    if ($urandom_range(4) == 0) fence_ctr = tag_ctr - $urandom_range(6);
    r.tag_seq  = ($urandom_range(49) == 0) ? $urandom() : tag_ctr;
    r.done_seq = ($urandom_range(49) == 0) ? $urandom() : fence_ctr;
    return r;
  endfunction

  typedef struct {
    req_t   r;
    bit     chk;  // typed-in expectation present
    grant_t g;
  } row_t;

  row_t        dir_rows [ROW_MAX];
  int unsigned n_rows;

  function automatic void add_row(logic cmd, int unsigned nb, int unsigned al,
                                  int unsigned tg, int unsigned dn, bit chk, grant_t g);
    row_t w;
    w.r = '{done_seq: dn, tag_seq: tg, alg: ALG_W'(al), nbytes: OFF_W'(nb), cmd: cmd};
    w.chk = chk;
    w.g = g;
    dir_rows[n_rows] = w;
    n_rows++;
  endfunction

  initial begin
    grant_t g;
    int unsigned clg_set[4];
    clg_set = '{12, 30, 5, 16};
    fail_cnt = 0;
    exp_wr = 0;
    exp_rd = 0;
    n_rows = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 0;
    ring_head = 0; ring_fill = 0; cursor = 0; slab_gen = 0; force_reg = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; default 8 MiB slab after reset
    add_row(CMD_ALLOC, 0, 0, 1, 0, 1, '{live:0, rot:0, gen:0, granted:0, offset:0,
                                         status:ST_EMPTY});
    add_row(CMD_RECLAIM, 5, 3, 1, 0, 1, '{live:0, rot:0, gen:0, granted:0, offset:0,
                                           status:ST_RECLAIM});
    add_row(CMD_ALLOC, 1, 0, 1, 0, 1, '{live:1, rot:0, gen:0, granted:1, offset:0,
                                         status:ST_PLACED});
    add_row(CMD_ALLOC, 100, 4, 2, 0, 0, g);
    add_row(CMD_ALLOC, 31'h7FFF_FFFF, 0, 3, 0, 1, '{live:2, rot:0, gen:0,
                                         granted:31'h7FFF_FFFF, offset:0, status:ST_DEDIC});
    add_row(CMD_ALLOC, 1 << 23, 0, 4, 0, 0, g);
    add_row(CMD_ALLOC, 5, 31, 5, 32'hFFFF_FFFF, 0, g);
    add_row(CMD_ALLOC, 7, 16, 32'hFFFF_FFFF, 4, 0, g);
    add_row(CMD_ALLOC, 1 << 22, 2, 6, 4, 0, g);
    add_row(CMD_ALLOC, 1 << 22, 2, 7, 4, 0, g);
    add_row(CMD_ALLOC, 1000, 0, 8, 4, 0, g);
    // two rotations happened above: full slab at the cursor, then a wrap miss
    add_row(CMD_RECLAIM, 0, 0, 0, 32'hFFFF_FFFF, 1, '{live:0, rot:0, gen:2, granted:0,
                                                       offset:0, status:ST_RECLAIM});
    for (int i = 0; i < n_rows; i++) begin
      send_req(dir_rows[i].r);
      if (dir_rows[i].chk && exp_mem[(exp_wr - 1) % EXP_DEPTH] != dir_rows[i].g) begin
        $error("directed row %0d predicted %h, table %h", i,
               exp_mem[(exp_wr - 1) % EXP_DEPTH], dir_rows[i].g);
        fail_cnt++;
      end
    end
    wait_drained();

    // list full: 70 tiny slices that never retire
    for (int i = 0; i < 70; i++)
      send_req('{done_seq: 0, tag_seq: 32'hFFFF_FFF0, alg: 0, nbytes: 1, cmd: CMD_ALLOC});
    wait_drained();

    // random phases over several settings
    tag_ctr = 10; fence_ctr = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CAP_LOG2, clg_set[ph % 4]);
      write_reg(REG_FORCE, (ph == 5));
      cfg_we_i <= 1'b0;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (ph == 1) begin
        // long receiver hold-off while words keep arriving
        fork
          begin
            hold_recv = 1;
            repeat (600) @(posedge clk_i);
            hold_recv = 0;
          end
        join_none
        send_idle_pct = 0;
      end
      for (int i = 0; i < 105; i++) send_req(rand_req());
      wait_drained();
    end
    write_reg(REG_CAP_LOG2, CLG_RST);
    write_reg(REG_FORCE, 0);
    cfg_we_i <= 1'b0;

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/frs_pkg.sv
sv/frs_cell.sv
sv/fenced_ring_suballocator.sv
dv/tb_fenced_ring_suballocator.sv
